>>> rtl/utgl_pkg.sv
`timescale 1ns / 1ps

package utgl_pkg;

   // Decoder phase codes
   localparam logic [1:0] PHASE_LEAD = 2'd0;   // expect a lead byte
   localparam logic [1:0] PHASE_HOLD = 2'd1;   // two-byte lead held, wait for partner
   localparam logic [1:0] PHASE_SKIP = 2'd2;   // discard continuation bytes

   // Byte class boundaries
   localparam logic [7:0] MULTI_MIN   = 8'd128;
   localparam logic [7:0] THREE_MIN   = 8'd224;
   localparam logic [7:0] FOUR_MIN    = 8'd240;
   localparam logic [7:0] UPPER_MIN   = 8'd65;
   localparam logic [7:0] UPPER_MAX   = 8'd90;
   localparam logic [7:0] LOWER_MIN   = 8'd97;
   localparam logic [7:0] LOWER_MAX   = 8'd122;
   localparam logic [7:0] WS_LF       = 8'd10;
   localparam logic [7:0] WS_CR       = 8'd13;
   localparam logic [7:0] WS_CODE20   = 8'd20;
   localparam logic [7:0] WS_SPACE    = 8'd32;
   localparam logic [7:0] GREEK_LEAD0 = 8'd206;
   localparam logic [7:0] GREEK_LEAD1 = 8'd207;
   localparam logic [7:0] G0_MIN      = 8'd134;
   localparam logic [7:0] G0_MAX      = 8'd191;
   localparam logic [7:0] G0_HOLE     = 8'd135;
   localparam logic [7:0] G1_MIN      = 8'd128;
   localparam logic [7:0] G1_MAX      = 8'd142;

   localparam logic [1:0] SKIP_THREE  = 2'd2;
   localparam logic [1:0] SKIP_FOUR   = 2'd3;

   typedef struct packed {
      logic [1:0] phase;
      logic [7:0] held_lead;
      logic [1:0] skip_left;
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } entry_type;

   // Results of one request: zero, one or two entries
   typedef struct packed {
      logic [1:0] count;
      entry_type  first;
      entry_type  second;
   } result_type;

   function automatic logic ascii_kept(input logic [7:0] b);
      logic ws;
      ws = (b == WS_LF) || (b == WS_CR) || (b == WS_CODE20) || (b == WS_SPACE);
      return ws || ((b >= UPPER_MIN) && (b <= UPPER_MAX))
                || ((b >= LOWER_MIN) && (b <= LOWER_MAX));
   endfunction

   function automatic logic greek_pair(input logic [7:0] lead, input logic [7:0] nb);
      logic hit;
      hit = 1'b0;
      if (lead == GREEK_LEAD0) begin
         hit = (nb >= G0_MIN) && (nb <= G0_MAX) && (nb != G0_HOLE);
      end else if (lead == GREEK_LEAD1) begin
         hit = (nb >= G1_MIN) && (nb <= G1_MAX);
      end
      return hit;
   endfunction

endpackage

>>> rtl/utgl_decode.sv
`timescale 1ns / 1ps

module utgl_decode (
   input  utgl_pkg::state_type  state_cur,
   input  logic [7:0]           in_byte,
   output utgl_pkg::state_type  state_nxt,
   output utgl_pkg::result_type result
);

   always_comb begin
      state_nxt                 = state_cur;
      result                    = '0;
      result.first.out_byte     = in_byte;
      result.first.last_of_run  = 1'b1;
      result.second.out_byte    = in_byte;
      result.second.last_of_run = 1'b1;

      unique case (state_cur.phase)
         utgl_pkg::PHASE_HOLD: begin
            state_nxt.phase     = utgl_pkg::PHASE_LEAD;
            state_nxt.held_lead = '0;
            if (utgl_pkg::greek_pair(state_cur.held_lead, in_byte)) begin
               // emit the held lead, then the partner closes the run
               result.count             = 2'd2;
               result.first.out_byte    = state_cur.held_lead;
               result.first.last_of_run = 1'b0;
            end
         end
         utgl_pkg::PHASE_SKIP: begin
            if (state_cur.skip_left <= 2'd1) begin
               state_nxt.skip_left = '0;
               state_nxt.phase     = utgl_pkg::PHASE_LEAD;
            end else begin
               state_nxt.skip_left = state_cur.skip_left - 2'd1;
            end
         end
         default: begin
            // lead expected; the unused phase code lands here too
            state_nxt.phase = utgl_pkg::PHASE_LEAD;
            if (in_byte < utgl_pkg::MULTI_MIN) begin
               if (utgl_pkg::ascii_kept(in_byte)) begin
                  result.count = 2'd1;
               end
            end else if (in_byte < utgl_pkg::THREE_MIN) begin
               state_nxt.held_lead = in_byte;
               state_nxt.phase     = utgl_pkg::PHASE_HOLD;
            end else begin
               state_nxt.skip_left = (in_byte < utgl_pkg::FOUR_MIN) ?
                                     utgl_pkg::SKIP_THREE : utgl_pkg::SKIP_FOUR;
               state_nxt.phase     = utgl_pkg::PHASE_SKIP;
            end
         end
      endcase
   end

endmodule

>>> rtl/utgl_out_queue.sv
`timescale 1ns / 1ps

module utgl_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  utgl_pkg::result_type push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_run
);

   utgl_pkg::entry_type mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   // room for a full pair
   assign room            = (count_ff <= 3'd2);
   assign rsp_valid       = (count_ff != 3'd0);
   assign pop             = rsp_valid && !rsp_stall;
   assign rsp_out_byte    = mem_ff[rd_ptr_ff].out_byte;
   assign rsp_last_of_run = mem_ff[rd_ptr_ff].last_of_run;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff]         <= push.first;
         mem_ff[wr_ptr_ff + 2'd1]  <= push.second;
      end else if (push.count == 2'd1) begin
         mem_ff[wr_ptr_ff]         <= push.first;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/utf8_greek_latin_text_filter.sv
`timescale 1ns / 1ps

// UTF-8 text filter: keeps ASCII letters, the codes 10, 13, 20 and 32, and
// two-byte Greek letters; drops everything else.
// Request channel: req_valid / req_stall carry one raw byte (req_in_byte).
// Response channel: rsp_valid / rsp_stall carry one kept byte (rsp_out_byte)
// with rsp_last_of_run set on the final byte produced by a request. A kept
// Greek pair comes out as two responses after its second byte arrives.
// Path: a taken request is held in the input register, decoded from it once
// the queue has room, and its responses are registered in the response queue.
// Throughput: one request per cycle, limited by the four-entry response
// queue, which must have room for a full pair before the input register
// drains into it.
// Reset: clears the decoder phase, held lead, skip count, input register and
// the response queue; nothing is pending afterward.
// Stall: a stalled response holds in the queue; once it fills past two
// entries a byte in the input register holds there and req_stall rises.

module utf8_greek_latin_text_filter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff, in_byte_in;
   utgl_pkg::state_type  state_ff, state_in, state_nxt;
   utgl_pkg::result_type result, push;
   logic                 room;
   logic                 accept;
   logic                 fire;

   // drain the input register whenever the queue can take a pair
   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   utgl_decode u_decode (
      .state_cur (state_ff),
      .in_byte   (in_byte_ff),
      .state_nxt (state_nxt),
      .result    (result)
   );

   always_comb begin
      push        = result;
      push.count  = fire ? result.count : 2'd0;
      state_in    = fire ? state_nxt : state_ff;
      in_byte_in  = accept ? req_in_byte : in_byte_ff;
      in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   end

   utgl_out_queue u_out_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .room            (room),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // payload: no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '{phase: utgl_pkg::PHASE_LEAD, held_lead: 8'd0, skip_left: 2'd0};
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

endmodule
